// File: rtl/core/sqf_pkg.sv
`timescale 1ns / 1ps

package sqf_pkg;

   localparam int NUMBER_WIDTH_DEFAULT = 31;

   localparam int STEP_WIDTH = 4;
   typedef logic [STEP_WIDTH-1:0] step_type;

   // Program addresses
   localparam step_type STEP_IDLE   = 4'd0;
   localparam step_type STEP_TEST   = 4'd1;
   localparam step_type STEP_DIV    = 4'd2;
   localparam step_type STEP_CHECK  = 4'd3;
   localparam step_type STEP_ADV    = 4'd4;
   localparam step_type STEP_EMIT0  = 4'd5;
   localparam step_type STEP_RET0   = 4'd6;
   localparam step_type STEP_EMIT1  = 4'd7;
   localparam step_type STEP_RET1   = 4'd8;

   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_NO_REQ,
      COND_SQ_GT_V,
      COND_CNT_NZ,
      COND_REM_ZERO,
      COND_OUT_FULL
   } cond_type;

   typedef struct packed {
      logic     accept;
      logic     div_step;
      logic     adv;
      logic     emit;
      logic     result;
      cond_type cond;
      step_type target;
   } ctl_word_type;

   typedef struct packed {
      logic sq_gt_v;
      logic cnt_nz;
      logic rem_zero;
      logic out_full;
   } status_type;

   // Control store: jump to target when cond holds, else fall through
   function automatic ctl_word_type ctl_rom(input step_type step);
      ctl_word_type w;
      w = '0;
      w.cond = COND_ALWAYS;
      w.target = STEP_IDLE;
      unique case (step)
         STEP_IDLE: begin
            w.accept = 1'b1;
            w.cond   = COND_NO_REQ;
            w.target = STEP_IDLE;
         end
         STEP_TEST: begin
            w.cond   = COND_SQ_GT_V;
            w.target = STEP_EMIT1;
         end
         STEP_DIV: begin
            w.div_step = 1'b1;
            w.cond     = COND_CNT_NZ;
            w.target   = STEP_DIV;
         end
         STEP_CHECK: begin
            w.cond   = COND_REM_ZERO;
            w.target = STEP_EMIT0;
         end
         STEP_ADV: begin
            w.adv    = 1'b1;
            w.cond   = COND_ALWAYS;
            w.target = STEP_TEST;
         end
         STEP_EMIT0: begin
            w.emit   = 1'b1;
            w.result = 1'b0;
            w.cond   = COND_OUT_FULL;
            w.target = STEP_EMIT0;
         end
         STEP_RET0: begin
            w.cond   = COND_ALWAYS;
            w.target = STEP_IDLE;
         end
         STEP_EMIT1: begin
            w.emit   = 1'b1;
            w.result = 1'b1;
            w.cond   = COND_OUT_FULL;
            w.target = STEP_EMIT1;
         end
         STEP_RET1: begin
            w.cond   = COND_ALWAYS;
            w.target = STEP_IDLE;
         end
         default: begin
            w.cond   = COND_ALWAYS;
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

// File: rtl/core/sqf_sequencer.sv
`timescale 1ns / 1ps

module sqf_sequencer
   import sqf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  status_type   status,
   output ctl_word_type ctl
);

   step_type pc_ff;
   step_type pc_in;
   logic     take;

   assign ctl = ctl_rom(pc_ff);

   always_comb begin
      unique case (ctl.cond)
         COND_ALWAYS:   take = 1'b1;
         COND_NO_REQ:   take = !req_valid;
         COND_SQ_GT_V:  take = status.sq_gt_v;
         COND_CNT_NZ:   take = status.cnt_nz;
         COND_REM_ZERO: take = status.rem_zero;
         COND_OUT_FULL: take = status.out_full;
         default:       take = 1'b1;
      endcase
   end

   always_comb begin
      pc_in = take ? ctl.target : step_type'(pc_ff + 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// File: rtl/core/sqf_datapath.sv
`timescale 1ns / 1ps

module sqf_datapath
   import sqf_pkg::*;
#(
   parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ctl_word_type            ctl,
   input  logic                    req_fire,
   input  logic [NUMBER_WIDTH-1:0] req_number,
   input  logic                    rsp_ready,
   output status_type              status,
   output logic                    rsp_valid,
   output logic                    rsp_is_squarefree
);

   localparam int W  = NUMBER_WIDTH;
   localparam int IW = (W + 1) / 2 + 1;
   localparam int CW = $clog2(W);
   localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);

   logic [W-1:0]  v_ff;
   logic [IW-1:0] i_ff;
   logic [W:0]    sq_ff;
   logic [W:0]    rem_ff;
   logic [W-1:0]  dv_ff;
   logic [CW-1:0] cnt_ff;
   logic          rsp_valid_ff;
   logic          rsp_bit_ff;

   logic [W:0]    shifted;
   logic [W:0]    rem_in;
   logic          out_full;

   assign out_full = rsp_valid_ff && !rsp_ready;

   // Restoring remainder, one dividend bit per step
   always_comb begin
      shifted = {rem_ff[W-1:0], dv_ff[W-1]};
      rem_in  = (shifted >= sq_ff) ? (shifted - sq_ff) : shifted;
   end

   always_comb begin
      status.sq_gt_v  = sq_ff > {1'b0, v_ff};
      status.cnt_nz   = cnt_ff != '0;
      status.rem_zero = rem_ff == '0;
      status.out_full = out_full;
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         v_ff   <= req_number;
         i_ff   <= IW'(2);
         sq_ff  <= (W + 1)'(4);
         rem_ff <= '0;
         dv_ff  <= req_number;
         cnt_ff <= CNT_LAST;
      end else if (ctl.adv) begin
         // (i+1)^2 = i^2 + 2i + 1
         i_ff   <= i_ff + 1'b1;
         sq_ff  <= sq_ff + (W + 1)'({i_ff, 1'b1});
         rem_ff <= '0;
         dv_ff  <= v_ff;
         cnt_ff <= CNT_LAST;
      end else if (ctl.div_step) begin
         rem_ff <= rem_in;
         dv_ff  <= {dv_ff[W-2:0], 1'b0};
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.emit && !out_full) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.emit && !out_full) begin
         rsp_bit_ff <= ctl.result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_is_squarefree = rsp_bit_ff;

endmodule

// File: rtl/core/squarefree_tester.sv
`timescale 1ns / 1ps

// Squarefree tester: each beat on req_ carries one unsigned number, and one
// beat on rsp_ returns is_squarefree, 1 when no square i*i with i >= 2
// divides the number (0, 1, 2 and 3 report 1). A small control store steps a
// datapath through trial divisions by 4, 9, 16, ... while the square does not
// exceed the number, stopping at the first exact division. The squares are
// built incrementally by an adder, and each remainder comes from a restoring
// divider that takes one dividend bit per cycle, so the work per item grows
// with its root r = floor(sqrt(number)) and ends early when a square divisor
// turns up. One item is worked on at a time; req_ready is high only while
// the sequencer sits idle, and the result register lets the next number be
// taken while an earlier result still waits on rsp_ready.
module squarefree_tester
   import sqf_pkg::*;
#(
   parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [NUMBER_WIDTH-1:0] req_number,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_is_squarefree
);

   ctl_word_type ctl;
   status_type   status;
   logic         req_fire;

   // Accept only in the idle step of the program
   assign req_ready = ctl.accept;
   assign req_fire  = req_valid && req_ready;

   // Step counter and control store
   sqf_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .ctl       (ctl)
   );

   // Operand, square, divider and result registers
   sqf_datapath #(
      .NUMBER_WIDTH (NUMBER_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .req_fire          (req_fire),
      .req_number        (req_number),
      .rsp_ready         (rsp_ready),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_is_squarefree (rsp_is_squarefree)
   );

`ifndef SYNTHESIS
   // Busy straight after taking a beat
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("req_ready high in the cycle after an accepted beat");

   // A non-squarefree verdict only follows an exact division
   a_zero_needs_divisor: assert property (@(posedge clock) disable iff (reset)
      (ctl.emit && !ctl.result) |-> status.rem_zero)
      else $error("verdict 0 issued with a non-zero remainder");

   // A squarefree verdict only once the square has passed the number
   a_one_needs_root: assert property (@(posedge clock) disable iff (reset)
      (ctl.emit && ctl.result) |-> status.sq_gt_v)
      else $error("verdict 1 issued before the trial squares ran out");
`endif

endmodule

// File: test/squarefree_checker.sv
`timescale 1ns / 1ps

module squarefree_checker
   import sqf_pkg::*;
#(
   parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic [NUMBER_WIDTH-1:0] req_number,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic                    rsp_is_squarefree,
   output int                      mismatch_count,
   output int                      verdicts_pending,
   output int                      verdicts_checked,
   output int                      square_hits
);

   typedef struct packed {
      logic [NUMBER_WIDTH-1:0] number;
      logic                    squarefree;
   } verdict_type;

   verdict_type verdicts_due[$];
   int mismatches = 0;
   int checked = 0;
   int hits = 0;

   // trial division by every square i*i, i >= 2, that does not exceed the number
   function automatic logic squarefree_verdict(input logic [NUMBER_WIDTH-1:0] number);
      longint unsigned value;
      longint unsigned trial;
      value = number;
      for (trial = 2; trial * trial <= value; trial++) begin
         if (value % (trial * trial) == 0)
            return 1'b0;
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin : track
      verdict_type due;
      if (reset) begin
         verdicts_due.delete();
      end else begin
         // retire the result beat before queueing a new number
         if (rsp_valid && rsp_ready) begin
            if (verdicts_due.size() == 0) begin
               mismatches++;
               $display("%0t: result beat %0b with no number outstanding",
                        $time, rsp_is_squarefree);
            end else begin
               due = verdicts_due.pop_front();
               checked++;
               if (!due.squarefree)
                  hits++;
               if (rsp_is_squarefree !== due.squarefree) begin
                  mismatches++;
                  $display("%0t: is_squarefree for %0d: expected %0b, actual %0b",
                           $time, due.number, due.squarefree, rsp_is_squarefree);
               end
            end
         end
         if (req_valid && req_ready) begin
            due.number     = req_number;
            due.squarefree = squarefree_verdict(req_number);
            verdicts_due.push_back(due);
         end
      end
      mismatch_count   <= mismatches;
      verdicts_pending <= verdicts_due.size();
      verdicts_checked <= checked;
      square_hits      <= hits;
   end

endmodule

// File: test/squarefree_tester_tb.sv
`timescale 1ns / 1ps

module squarefree_tester_tb
   import sqf_pkg::*;
();

   localparam int WIDTH = NUMBER_WIDTH_DEFAULT;
   localparam int RANDOM_ITEMS = 100;
   // long enough for two of the slowest random numbers to finish, so that the
   // result register and the stalled emit step both fill and req_ready drops
   localparam int HOLD_CYCLES = 40_000;
   // the largest number, a prime, runs the longest trial loop; allow a good margin
   localparam int QUIET_LIMIT = 8_000_000;
   localparam int CORNER_COUNT = 23;

   typedef enum logic [1:0] {
      RSP_ALWAYS,
      RSP_COIN,
      RSP_ONE_IN_FOUR,
      RSP_SPARSE
   } rsp_mode_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   logic [WIDTH-1:0] req_number;
   logic             rsp_valid;
   logic             rsp_ready;
   logic             rsp_is_squarefree;

   int mismatch_count;
   int verdicts_pending;
   int verdicts_checked;
   int square_hits;

   // sender bookkeeping
   int burst_left = 0;
   int numbers_sent = 0;
   int holds_asked = 0;
   logic [WIDTH-1:0] largest_sent = '0;

   // corner values: zero and the numbers below four, small squares and their
   // multiples, primes, a squarefree semiprime, the square of a prime (its only
   // square divisor sits right at the root), powers of two and the top of range
   int unsigned corner_numbers [CORNER_COUNT] = '{
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 12, 18, 25, 30, 49, 97, 210,
      65521, 1052651, 1062961, 1073741824, 2147483644, 2147483647
   };

   squarefree_tester #(
      .NUMBER_WIDTH(WIDTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_number(req_number),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_is_squarefree(rsp_is_squarefree)
   );

   squarefree_checker #(
      .NUMBER_WIDTH(WIDTH)
   ) checker_i (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_number(req_number),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_is_squarefree(rsp_is_squarefree),
      .mismatch_count(mismatch_count),
      .verdicts_pending(verdicts_pending),
      .verdicts_checked(verdicts_checked),
      .square_hits(square_hits)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Random numbers. The block's time grows with the square root of the
   // number, so keep most draws small and make the full-width ones carry a
   // small square factor, which ends the trial loop early.
   function automatic logic [WIDTH-1:0] draw_number();
      int unsigned     kind;
      longint unsigned root;
      longint unsigned value;
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
         value = $urandom_range(1, 4095);
      end else if (kind < 65) begin
         root  = $urandom_range(2, 40);
         value = root * root * $urandom_range(1, 2000);
      end else if (kind < 80) begin
         value = $urandom_range(1, 1 << 18);
      end else begin
         root  = $urandom_range(2, 7);
         value = $urandom & ((64'd1 << WIDTH) - 1);
         value = value - value % (root * root);
         if (value == 0)
            value = root * root;
      end
      return value[WIDTH-1:0];
   endfunction

   // Offer one number and hold it until the beat is taken. Bursts of random
   // length, with a random gap before each, shape the sender's pace.
   task automatic offer_number(input logic [WIDTH-1:0] number);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         // now and then a long burst with no gaps at all
         burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 8);
      end
      burst_left--;
      req_valid  <= 1'b1;
      req_number <= number;
      do @(posedge clock); while (!req_ready);
      numbers_sent++;
      if (number > largest_sent)
         largest_sent = number;
   endtask

   // Drop valid and wait until every outstanding verdict has come back.
   task automatic drain_verdicts();
      req_valid <= 1'b0;
      do @(posedge clock); while (verdicts_pending != 0);
      burst_left = 0;
   endtask

   // Receiver: a random stall pattern, redrawn after a random run, plus long
   // hold-offs on request so that the block fills up and refuses new numbers.
   initial begin : receiver
      int           holds_served;
      int           mode_left;
      int           tick;
      rsp_mode_type mode;
      holds_served = 0;
      mode_left    = 0;
      tick         = 0;
      mode         = RSP_ALWAYS;
      rsp_ready    = 1'b0;
      forever begin
         @(posedge clock);
         if (holds_served < holds_asked) begin
            holds_served++;
            rsp_ready <= 1'b0;
            for (int held = 0; held < HOLD_CYCLES; held++)
               @(posedge clock);
         end else begin
            if (mode_left == 0) begin
               mode      = rsp_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(16, 128);
            end
            mode_left--;
            tick++;
            case (mode)
               RSP_ALWAYS:      rsp_ready <= 1'b1;
               RSP_COIN:        rsp_ready <= 1'($urandom_range(0, 1));
               RSP_ONE_IN_FOUR: rsp_ready <= (tick % 4 == 0);
               default:         rsp_ready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   // Watchdog: end the run if nothing moves on either channel for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   initial begin : stimulus
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_number = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed corners first
      for (int k = 0; k < CORNER_COUNT; k++)
         offer_number(corner_numbers[k][WIDTH-1:0]);

      // let the block run dry before the random part
      drain_verdicts();

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         // hold the receiver off while the sender keeps offering
         if (k == 0 || k == 60)
            holds_asked <= holds_asked + 1;
         // and once mid-way pause the sender until the block is empty
         if (k == 30)
            drain_verdicts();
         offer_number(draw_number());
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (verdicts_pending != 0);
      // keep the clock running so that a stray result beat would still be caught
      repeat (20) @(posedge clock);

      $display("Sent %0d numbers (%0d corners, %0d random), largest %0d.",
               numbers_sent, CORNER_COUNT, RANDOM_ITEMS, largest_sent);
      $display("Checked %0d verdicts, %0d of them with a square divisor.",
               verdicts_checked, square_hits);
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
